/* hdl/qrv_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the quaternion vector rotation pipeline.
// No dependencies.
package qrv_pkg;

	localparam int QUAT_WIDTH_DEF = 16;
	localparam int VEC_WIDTH_DEF  = 24;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W = 2'd0,
		REG_QUAT_X = 2'd1,
		REG_QUAT_Y = 2'd2,
		REG_QUAT_Z = 2'd3
	} cfg_reg_t;

endpackage

/* hdl/quaternion_rotate_vector.sv */
`timescale 1ns / 1ps
// Quaternion vector rotation: rot = R(q) * vec / |q|^2, rounded and saturated.
// Depends on qrv_pkg.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes quat_w,
//    quat_x, quat_y, quat_z at indexes 0..3; other indexes are dropped.
//    cfg_ready is always high. Write only while no vector is in flight.
//  - in channel (in_valid/in_ready) carries vec_x/y/z; out channel
//    (out_valid/out_ready) returns rot_x/y/z, zero_norm and saturated.
//  - One vector per cycle sustained while out_ready is high. The
//    rounding divider retires one quotient bit per stage, after five
//    stages of products and sums.
//  - Each stage holds when it is full and the one after it is held, so
//    a stalled receiver fills the empty stages before in_ready drops.
//  - Reset loads the identity quaternion and empties the pipeline.
//  - A zero quaternion gives zero coordinates with zero_norm set.
module quaternion_rotate_vector
	import qrv_pkg::*;
#(
	parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
	parameter int VEC_WIDTH  = VEC_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [QUAT_WIDTH-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [VEC_WIDTH-1:0] vec_x,
	input  logic signed [VEC_WIDTH-1:0] vec_y,
	input  logic signed [VEC_WIDTH-1:0] vec_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [VEC_WIDTH-1:0] rot_x,
	output logic signed [VEC_WIDTH-1:0] rot_y,
	output logic signed [VEC_WIDTH-1:0] rot_z,
	output logic                        zero_norm,
	output logic                        saturated
);

	localparam int Q  = QUAT_WIDTH;
	localparam int V  = VEC_WIDTH;
	localparam int PQ = 2 * Q;
	localparam int MW = 2 * Q + 2;
	localparam int PW = MW + V;
	localparam int AW = PW + 2;
	localparam int DW = AW + 2;
	localparam int NS = V + 7;

	logic signed [Q-1:0] qw_q, qx_q, qy_q, qz_q;
	logic [NS-1:0]       vld_s;
	logic [NS-1:0]       adv;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= Q'(1) << (Q - 2);
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_QUAT_W: qw_q <= cfg_data;
				REG_QUAT_X: qx_q <= cfg_data;
				REG_QUAT_Y: qy_q <= cfg_data;
				REG_QUAT_Z: qz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: a stage moves when empty or when the next one moves
	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || out_ready;
		for (int s = NS - 2; s >= 0; s--) begin
			adv[s] = !vld_s[s] || adv[s+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int s = 1; s < NS; s++) begin
				if (adv[s]) begin
					vld_s[s] <= vld_s[s-1];
				end
			end
		end
	end

	// s1: quaternion products
	logic signed [PQ-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [V-1:0]  p_s1 [0:2];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ww_s1   <= qw_q * qw_q;
			xx_s1   <= qx_q * qx_q;
			yy_s1   <= qy_q * qy_q;
			zz_s1   <= qz_q * qz_q;
			xy_s1   <= qx_q * qy_q;
			wz_s1   <= qw_q * qz_q;
			xz_s1   <= qx_q * qz_q;
			wy_s1   <= qw_q * qy_q;
			yz_s1   <= qy_q * qz_q;
			wx_s1   <= qw_q * qx_q;
			p_s1[0] <= vec_x;
			p_s1[1] <= vec_y;
			p_s1[2] <= vec_z;
		end
	end

	// s2: rotation matrix scaled by the norm, and the norm
	logic signed [MW-1:0] m_s2 [0:2][0:2];
	logic signed [MW-1:0] n_s2;
	logic signed [V-1:0]  p_s2 [0:2];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			m_s2[0][0] <= MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
			m_s2[0][1] <= (MW'(xy_s1) - MW'(wz_s1)) <<< 1;
			m_s2[0][2] <= (MW'(xz_s1) + MW'(wy_s1)) <<< 1;
			m_s2[1][0] <= (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
			m_s2[1][1] <= MW'(ww_s1) - MW'(xx_s1) + MW'(yy_s1) - MW'(zz_s1);
			m_s2[1][2] <= (MW'(yz_s1) - MW'(wx_s1)) <<< 1;
			m_s2[2][0] <= (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
			m_s2[2][1] <= (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
			m_s2[2][2] <= MW'(ww_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
			n_s2       <= MW'(ww_s1) + MW'(xx_s1) + MW'(yy_s1) + MW'(zz_s1);
			p_s2       <= p_s1;
		end
	end

	// s3: matrix times vector, one product per entry
	logic signed [PW-1:0] mp_s3 [0:2][0:2];
	logic signed [MW-1:0] n_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mp_s3[i][j] <= PW'(m_s2[i][j]) * PW'(p_s2[j]);
				end
			end
			n_s3 <= n_s2;
		end
	end

	// s4: row sums
	logic signed [AW-1:0] num_s4 [0:2];
	logic signed [MW-1:0] n_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= AW'(mp_s3[i][0]) + AW'(mp_s3[i][1]) + AW'(mp_s3[i][2]);
			end
			n_s4 <= n_s3;
		end
	end

	// s5 and divider: q = (2|num| + n) / (2n), one quotient bit per stage
	logic [DW-1:0] rem_sd [0:V+1][0:2];
	logic [V:0]    quo_sd [0:V+1][0:2];
	logic [2:0]    neg_sd [0:V+1];
	logic [MW:0]   dvs_sd [0:V+1];
	logic          zn_sd  [0:V+1];

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < 3; i++) begin
				neg_sd[0][i] <= num_s4[i][AW-1];
				rem_sd[0][i] <= (DW'(num_s4[i][AW-1] ? -num_s4[i] : num_s4[i]) << 1)
					+ DW'(unsigned'(n_s4));
				quo_sd[0][i] <= '0;
			end
			dvs_sd[0] <= {unsigned'(n_s4), 1'b0};
			zn_sd[0]  <= (n_s4 == '0);
		end
	end

	for (genvar k = 0; k <= V; k++) begin : g_div
		localparam int B = V - k;
		logic [DW:0] dif [0:2];

		for (genvar a = 0; a < 3; a++) begin : g_ax
			assign dif[a] = {1'b0, rem_sd[k][a]} - {1'b0, DW'(dvs_sd[k]) << B};
		end

		always_ff @(posedge clk) begin
			if (adv[5+k]) begin
				for (int a = 0; a < 3; a++) begin
					rem_sd[k+1][a] <= dif[a][DW] ? rem_sd[k][a] : dif[a][DW-1:0];
					quo_sd[k+1][a] <= quo_sd[k][a] | ((V+1)'(!dif[a][DW]) << B);
				end
				neg_sd[k+1] <= neg_sd[k];
				dvs_sd[k+1] <= dvs_sd[k];
				zn_sd[k+1]  <= zn_sd[k];
			end
		end
	end

	// output stage: saturate and restore sign
	logic [V:0]   lim   [0:2];
	logic [V:0]   mag   [0:2];
	logic [V:0]   sres  [0:2];
	logic [2:0]   over;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lim[a]  = neg_sd[V+1][a] ? ((V+1)'(1) << (V - 1))
				: (((V+1)'(1) << (V - 1)) - (V+1)'(1));
			over[a] = quo_sd[V+1][a] > lim[a];
			mag[a]  = over[a] ? lim[a] : quo_sd[V+1][a];
			sres[a] = neg_sd[V+1][a] ? (~mag[a] + (V+1)'(1)) : mag[a];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			rot_x     <= zn_sd[V+1] ? '0 : sres[0][V-1:0];
			rot_y     <= zn_sd[V+1] ? '0 : sres[1][V-1:0];
			rot_z     <= zn_sd[V+1] ? '0 : sres[2][V-1:0];
			zero_norm <= zn_sd[V+1];
			saturated <= !zn_sd[V+1] && (over != 3'b000);
		end
	end

	localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
	localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> rot_x == '0 && rot_y == '0 && rot_z == '0 && !saturated)
		else $error("zero norm result not cleared");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> rot_x == VMAX || rot_x == VMIN || rot_y == VMAX
			|| rot_y == VMIN || rot_z == VMAX || rot_z == VMIN)
		else $error("saturated flag without clipped coordinate");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held while output stage empty");

endmodule
